@@ design/rsie_pkg.sv @@
// Shared types and encodings for the RISC subset executor.
package rsie_pkg;

  typedef enum logic [1:0] {
    OP_EXEC     = 2'd0,
    OP_PRELOAD  = 2'd1,
    OP_READ_REG = 2'd2,
    OP_READ_MEM = 2'd3
  } op_e;

  localparam logic [5:0] OPC_RTYPE  = 6'd0;
  localparam logic [5:0] OPC_RTYPE2 = 6'd28;
  localparam logic [5:0] OPC_LW     = 6'd35;
  localparam logic [5:0] OPC_SW     = 6'd43;
  localparam logic [5:0] OPC_ADDI   = 6'd8;
  localparam logic [5:0] OPC_BEQ    = 6'd4;
  localparam logic [5:0] OPC_J      = 6'd2;

  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_NOR = 6'd7;
  localparam logic [5:0] FN_MUL = 6'd2;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;
  localparam logic [4:0]  REG_ZERO  = 5'd0;
  localparam int unsigned NUM_REGS  = 32;

  typedef struct packed {
    op_e         op;
    logic [31:0] instr;
    logic [9:0]  index;
    logic [31:0] data;
  } item_t;

  typedef struct packed {
    logic        rf_we;
    logic        ld;
    logic [4:0]  rf_addr;
    logic [31:0] rf_data;
    logic        mem_we;
    logic        mem_re;
    logic        rd_out;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic [31:0] read_value;
    logic [31:0] pc;
    logic        halted;
  } exec_t;

endpackage

@@ design/rsie_regfile.sv @@
// 32x32 register file, one write port and two registered read ports.
module rsie_regfile import rsie_pkg::*; (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [4:0]  waddr_i,
  input  logic [31:0] wdata_i,
  input  logic        re_i,
  input  logic [4:0]  raddr_a_i,
  input  logic [4:0]  raddr_b_i,
  output logic [31:0] rdata_a_o,
  output logic [31:0] rdata_b_o
);

  logic [31:0] mem_q [NUM_REGS];
  logic [31:0] rdata_a_q;
  logic [31:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ design/rsie_dmem.sv @@
// Word-indexed data store with one write port and one registered read port.
module rsie_dmem import rsie_pkg::*; #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(DATA_WORDS)-1:0] waddr_i,
  input  logic [31:0]                   wdata_i,
  input  logic                          re_i,
  input  logic [$clog2(DATA_WORDS)-1:0] raddr_i,
  output logic [31:0]                   rdata_o
);

  logic [31:0] mem_q [DATA_WORDS];
  logic [31:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/rsie_exec.sv @@
// Decode, ALU, address and next-PC logic for one request.
module rsie_exec import rsie_pkg::*; (
  input  item_t       item_i,
  input  logic [31:0] rs_val_i,
  input  logic [31:0] rt_val_i,
  input  logic [31:0] pc_i,
  input  logic        halted_i,
  output exec_t       ex_o
);

  logic [5:0]  opc;
  logic [5:0]  funct;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [31:0] imm;
  logic [31:0] pc4;
  logic [31:0] addr_sum;
  logic [31:0] alu_res;
  logic        alu_ok;

  assign opc      = item_i.instr[31:26];
  assign funct    = item_i.instr[5:0];
  assign rt       = item_i.instr[20:16];
  assign rd       = item_i.instr[15:11];
  assign imm      = {{16{item_i.instr[15]}}, item_i.instr[15:0]};
  assign pc4      = pc_i + 32'd4;
  assign addr_sum = rs_val_i + imm;

  always_comb begin
    alu_ok  = 1'b1;
    alu_res = '0;
    case (funct)
      FN_ADD:  alu_res = rs_val_i + rt_val_i;
      FN_SUB:  alu_res = rs_val_i - rt_val_i;
      FN_AND:  alu_res = rs_val_i & rt_val_i;
      FN_OR:   alu_res = rs_val_i | rt_val_i;
      FN_NOR:  alu_res = ~(rs_val_i | rt_val_i);
      FN_MUL:  alu_res = rs_val_i * rt_val_i;
      default: alu_ok  = 1'b0;
    endcase
  end

  always_comb begin
    ex_o        = '0;
    ex_o.pc     = pc_i;
    ex_o.halted = halted_i;
    case (item_i.op)
      OP_EXEC: begin
        if (!halted_i) begin
          if (item_i.instr == HALT_WORD) begin
            ex_o.halted = 1'b1;
          end else begin
            ex_o.pc = pc4;
            case (opc)
              OPC_RTYPE, OPC_RTYPE2: begin
                ex_o.rf_we   = alu_ok && (rd != REG_ZERO);
                ex_o.rf_addr = rd;
                ex_o.rf_data = alu_res;
              end
              OPC_LW: begin
                ex_o.mem_re   = 1'b1;
                ex_o.mem_addr = addr_sum;
                ex_o.ld       = (rt != REG_ZERO);
                ex_o.rf_addr  = rt;
              end
              OPC_SW: begin
                ex_o.mem_we    = 1'b1;
                ex_o.mem_addr  = addr_sum;
                ex_o.mem_wdata = rt_val_i;
              end
              OPC_ADDI: begin
                ex_o.rf_we   = (rt != REG_ZERO);
                ex_o.rf_addr = rt;
                ex_o.rf_data = addr_sum;
              end
              OPC_BEQ: begin
                if (rs_val_i == rt_val_i) begin
                  ex_o.pc = pc4 + {imm[29:0], 2'b00};
                end
              end
              OPC_J: begin
                ex_o.pc = {pc4[31:28], item_i.instr[25:0], 2'b00};
              end
              default: ;
            endcase
          end
        end
      end
      OP_PRELOAD: begin
        ex_o.mem_we    = 1'b1;
        ex_o.mem_addr  = {22'd0, item_i.index};
        ex_o.mem_wdata = item_i.data;
      end
      OP_READ_REG: begin
        ex_o.read_value = rs_val_i;
      end
      OP_READ_MEM: begin
        ex_o.mem_re   = 1'b1;
        ex_o.rd_out   = 1'b1;
        ex_o.mem_addr = {22'd0, item_i.index};
      end
      default: ;
    endcase
  end

endmodule

@@ design/risc_subset_instruction_executor_unit.sv @@
// Top level of the RISC subset executor: pipeline, forwarding and clear sequencer.
//
//   channel | dir | tdata (low bit up)                        | tuser
//   s_axis  | in  | instr_word, index, data_value, zero pad   | op
//   m_axis  | out | next_pc, halted, read_value, fault, pad   | -
//
// One request per cycle while the output is not stalled; each result passes through the
// entry/register read, execute/data access and writeback/output register stages.
// After reset a clearing pass zeroes the data store and register file; s_axis_tready
// stays low during it.
// m_axis_tready low while a result waits freezes the pipeline; one request arriving then
// is held in a skid register, so s_axis_tready depends only on registers.
module risc_subset_instruction_executor_unit import rsie_pkg::*; #(
  parameter int unsigned DATA_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // instr_word[31:0], index[41:32], data_value[73:42]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata    // next_pc[31:0], halted[32], read_value[64:33], fault[65]
);

  localparam int unsigned AW      = $clog2(DATA_WORDS);
  localparam int unsigned CLR_CNT = (DATA_WORDS > NUM_REGS) ? DATA_WORDS : NUM_REGS;
  localparam int unsigned CW      = $clog2(CLR_CNT);

  typedef struct packed {
    logic        rf_we;
    logic        ld;
    logic        rd_mem;
    logic [4:0]  rf_addr;
    logic [31:0] rf_data;
    logic [31:0] read_value;
    logic [31:0] pc;
    logic        halted;
    logic        fault;
  } cstage_t;

  logic          clr_busy_q;
  logic [CW-1:0] clr_cnt_q;

  logic          pipe_adv;
  item_t         s_item;
  logic          s_accept;
  logic          skid_valid_q;
  item_t         skid_q;
  item_t         ent_item;
  logic          ent_valid;
  logic [4:0]    ent_rs;

  logic          b_valid_q;
  item_t         b_q;
  logic [4:0]    b_rs;
  logic [4:0]    b_rt;
  logic [31:0]   rf_rdata_a;
  logic [31:0]   rf_rdata_b;
  logic [31:0]   rs_val;
  logic [31:0]   rt_val;
  exec_t         ex;
  logic          b_in_range;
  logic          b_fault;

  logic          c_valid_q;
  cstage_t       c_q;
  logic          c_we;
  logic [31:0]   c_wdata;
  logic [31:0]   dmem_rdata;

  logic          wb_valid_q;
  logic [4:0]    wb_addr_q;
  logic [31:0]   wb_data_q;

  logic          o_valid_q;
  logic [31:0]   o_pc_q;
  logic          o_halted_q;
  logic [31:0]   o_read_q;
  logic          o_fault_q;

  logic [31:0]   pc_q;
  logic          halt_q;

  logic          rf_we;
  logic [4:0]    rf_waddr;
  logic [31:0]   rf_wdata;
  logic          dmem_we;
  logic [AW-1:0] dmem_waddr;
  logic [31:0]   dmem_wdata;

  // Input side and skid register
  assign s_item.op    = op_e'(s_axis_tuser);
  assign s_item.instr = s_axis_tdata[31:0];
  assign s_item.index = s_axis_tdata[41:32];
  assign s_item.data  = s_axis_tdata[73:42];

  assign s_axis_tready = !skid_valid_q && !clr_busy_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign pipe_adv      = !o_valid_q || m_axis_tready;

  assign ent_item  = skid_valid_q ? skid_q : s_item;
  assign ent_valid = skid_valid_q || s_accept;
  assign ent_rs    = (ent_item.op == OP_READ_REG) ? ent_item.index[4:0]
                                                  : ent_item.instr[25:21];

  // Clear sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == CW'(CLR_CNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
      b_valid_q    <= 1'b0;
      c_valid_q    <= 1'b0;
      o_valid_q    <= 1'b0;
      wb_valid_q   <= 1'b0;
      pc_q         <= '0;
      halt_q       <= 1'b0;
    end else begin
      if (pipe_adv) begin
        skid_valid_q <= 1'b0;
        b_valid_q    <= ent_valid;
        c_valid_q    <= b_valid_q;
        o_valid_q    <= c_valid_q;
        wb_valid_q   <= c_we;
        if (b_valid_q) begin
          pc_q   <= ex.pc;
          halt_q <= ex.halted;
        end
      end else if (s_accept) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (!pipe_adv && s_accept) begin
      skid_q <= s_item;
    end
    if (pipe_adv) begin
      b_q               <= ent_item;
      c_q.rf_we         <= ex.rf_we;
      c_q.ld            <= ex.ld && b_in_range;
      c_q.rd_mem        <= ex.rd_out && b_in_range;
      c_q.rf_addr       <= ex.rf_addr;
      c_q.rf_data       <= ex.rf_data;
      c_q.read_value    <= ex.read_value;
      c_q.pc            <= ex.pc;
      c_q.halted        <= ex.halted;
      c_q.fault         <= b_fault;
      wb_addr_q         <= c_q.rf_addr;
      wb_data_q         <= c_wdata;
      o_pc_q            <= c_q.pc;
      o_halted_q        <= c_q.halted;
      o_read_q          <= c_q.rd_mem ? dmem_rdata : c_q.read_value;
      o_fault_q         <= c_q.fault;
    end
  end

  // Execute stage with forwarding from writeback and the last completed write
  assign b_rs = (b_q.op == OP_READ_REG) ? b_q.index[4:0] : b_q.instr[25:21];
  assign b_rt = b_q.instr[20:16];

  always_comb begin
    if (c_we && (c_q.rf_addr == b_rs)) begin
      rs_val = c_wdata;
    end else if (wb_valid_q && (wb_addr_q == b_rs)) begin
      rs_val = wb_data_q;
    end else begin
      rs_val = rf_rdata_a;
    end
    if (c_we && (c_q.rf_addr == b_rt)) begin
      rt_val = c_wdata;
    end else if (wb_valid_q && (wb_addr_q == b_rt)) begin
      rt_val = wb_data_q;
    end else begin
      rt_val = rf_rdata_b;
    end
  end

  rsie_exec u_exec (
    .item_i   (b_q),
    .rs_val_i (rs_val),
    .rt_val_i (rt_val),
    .pc_i     (pc_q),
    .halted_i (halt_q),
    .ex_o     (ex)
  );

  assign b_in_range = ex.mem_addr < 32'(DATA_WORDS);
  assign b_fault    = (ex.mem_we || ex.mem_re) && !b_in_range;

  // Writeback
  assign c_we    = c_valid_q && (c_q.rf_we || c_q.ld);
  assign c_wdata = c_q.ld ? dmem_rdata : c_q.rf_data;

  // Memory write ports: clear sweep or pipeline
  always_comb begin
    if (clr_busy_q) begin
      rf_we      = 32'(clr_cnt_q) < 32'(NUM_REGS);
      rf_waddr   = clr_cnt_q[4:0];
      rf_wdata   = '0;
      dmem_we    = 32'(clr_cnt_q) < 32'(DATA_WORDS);
      dmem_waddr = clr_cnt_q[AW-1:0];
      dmem_wdata = '0;
    end else begin
      rf_we      = pipe_adv && c_we;
      rf_waddr   = c_q.rf_addr;
      rf_wdata   = c_wdata;
      dmem_we    = pipe_adv && b_valid_q && ex.mem_we && b_in_range;
      dmem_waddr = ex.mem_addr[AW-1:0];
      dmem_wdata = ex.mem_wdata;
    end
  end

  rsie_regfile u_regfile (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .re_i      (pipe_adv),
    .raddr_a_i (ent_rs),
    .raddr_b_i (ent_item.instr[20:16]),
    .rdata_a_o (rf_rdata_a),
    .rdata_b_o (rf_rdata_b)
  );

  rsie_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dmem_we),
    .waddr_i (dmem_waddr),
    .wdata_i (dmem_wdata),
    .re_i    (pipe_adv),
    .raddr_i (ex.mem_addr[AW-1:0]),
    .rdata_o (dmem_rdata)
  );

  // Output side
  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = {6'd0, o_fault_q, o_read_q, o_halted_q, o_pc_q};

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !(skid_valid_q || b_valid_q || c_valid_q || o_valid_q))
    else $error("pipeline active during clearing pass");

  a_no_r0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rf_we && !clr_busy_q) |-> (rf_waddr != REG_ZERO))
    else $error("register zero written");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag cleared without reset");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> !$past(pipe_adv))
    else $error("skid register filled while pipeline advanced");

  a_fault_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && b_fault && !clr_busy_q) |-> !dmem_we)
    else $error("data store written on out-of-range request");

endmodule

@@ verif/risc_subset_instruction_executor_unit_tb.sv @@
// Self-checking testbench for the RISC subset executor: predicts each result and compares it.
module risc_subset_instruction_executor_unit_tb import rsie_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_WORDS = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        fault;
    logic [31:0] read_value;
    logic        halted;
    logic [31:0] next_pc;
  } result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;   // instr_word[31:0], index[41:32], data_value[73:42]
  logic [1:0]  s_axis_tuser;   // op[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;   // next_pc[31:0], halted[32], read_value[64:33], fault[65]

  logic [31:0] gpr [NUM_REGS];
  logic [31:0] dmem [DATA_WORDS];
  logic [31:0] pc_q;
  logic        halt_q;

  result_t     pending_results [$];
  result_t     got_r;
  result_t     want_r;
  int unsigned mismatches;
  int unsigned cycles;
  bit          tx_idle_en;
  bit          rx_idle_en;
  int unsigned rx_hold_left;
  int unsigned rx_gap_left;

  risc_subset_instruction_executor_unit #(
    .DATA_WORDS(DATA_WORDS)
  ) DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic void write_gpr(input logic [4:0] r, input logic [31:0] v);
    if (r != REG_ZERO) gpr[r] = v;
  endfunction

  function automatic result_t apply_request(input op_e op, input logic [31:0] w,
                                            input logic [9:0] idx, input logic [31:0] val);
    result_t     r;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [31:0] imm;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc4;
    logic [31:0] addr;
    r = '0;
    rs = w[25:21];
    rt = w[20:16];
    rd = w[15:11];
    imm = {{16{w[15]}}, w[15:0]};
    a = gpr[rs];
    b = gpr[rt];
    pc4 = pc_q + 32'd4;
    case (op)
      OP_EXEC: begin
        if (!halt_q && w == HALT_WORD) begin
          halt_q = 1'b1;
        end else if (!halt_q) begin
          case (w[31:26])
            OPC_RTYPE, OPC_RTYPE2: begin
              case (w[5:0])
                FN_ADD: write_gpr(rd, a + b);
                FN_SUB: write_gpr(rd, a - b);
                FN_AND: write_gpr(rd, a & b);
                FN_OR:  write_gpr(rd, a | b);
                FN_NOR: write_gpr(rd, ~(a | b));
                FN_MUL: write_gpr(rd, a * b);
                default: ;
              endcase
            end
            OPC_LW, OPC_SW: begin
              addr = a + imm;
              if (addr >= DATA_WORDS) r.fault = 1'b1;
              else if (w[31:26] == OPC_LW) write_gpr(rt, dmem[addr]);
              else dmem[addr] = b;
            end
            OPC_ADDI: write_gpr(rt, a + imm);
            OPC_BEQ:  if (a == b) pc4 = pc4 + {imm[29:0], 2'b00};
            OPC_J:    pc4 = {pc4[31:28], w[25:0], 2'b00};
            default: ;
          endcase
          pc_q = pc4;
        end
      end
      OP_PRELOAD: begin
        if (idx < DATA_WORDS) dmem[idx] = val;
        else r.fault = 1'b1;
      end
      OP_READ_REG: r.read_value = gpr[idx[4:0]];
      default: begin
        if (idx < DATA_WORDS) r.read_value = dmem[idx];
        else r.fault = 1'b1;
      end
    endcase
    r.next_pc = pc_q;
    r.halted = halt_q;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [4:0] rd,
                                        input logic [5:0] fn);
    return {opc, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] opc, input logic [4:0] rs,
                                        input logic [4:0] rt, input logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  task automatic issue_request(input op_e op, input logic [31:0] w,
                               input logic [9:0] idx, input logic [31:0] val);
    int unsigned gap;
    @(negedge clk_i);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {6'd0, val, idx, w};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(op, w, idx, val));
  endtask

  task automatic exec_instr(input logic [31:0] w);
    issue_request(OP_EXEC, w, 10'd0, 32'd0);
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_alu_ops();
    exec_instr(enc_i(OPC_ADDI, REG_ZERO, 5'd1, 16'h7FFF));
    exec_instr(enc_i(OPC_ADDI, REG_ZERO, 5'd2, 16'h8000));
    exec_instr(enc_r(OPC_RTYPE,  5'd1, 5'd2, 5'd3, FN_ADD));
    exec_instr(enc_r(OPC_RTYPE2, 5'd1, 5'd2, 5'd4, FN_SUB));
    exec_instr(enc_r(OPC_RTYPE,  5'd1, 5'd2, 5'd5, FN_AND));
    exec_instr(enc_r(OPC_RTYPE2, 5'd1, 5'd2, 5'd6, FN_OR));
    exec_instr(enc_r(OPC_RTYPE,  REG_ZERO, REG_ZERO, 5'd7, FN_NOR));
    exec_instr(enc_r(OPC_RTYPE2, 5'd7, 5'd2, 5'd8, FN_MUL));
    exec_instr(enc_r(OPC_RTYPE,  5'd1, 5'd1, 5'd9, 6'd63));
    exec_instr(enc_r(OPC_RTYPE,  5'd7, 5'd1, REG_ZERO, FN_ADD));
    exec_instr(enc_r(OPC_RTYPE2, 5'd7, 5'd7, 5'd9, FN_ADD));
    issue_request(OP_READ_REG, 32'd0, 10'h3FF, 32'd0);
    issue_request(OP_READ_REG, 32'd0, 10'd8, 32'd0);
  endtask

  task automatic test_memory_and_branch();
    issue_request(OP_PRELOAD, 32'd0, 10'h3FF, 32'hFFFF_FFFF);
    issue_request(OP_PRELOAD, 32'd0, 10'd0, 32'hA5A5_5A5A);
    issue_request(OP_READ_MEM, 32'd0, 10'h3FF, 32'd0);
    exec_instr(enc_i(OPC_LW, REG_ZERO, 5'd10, 16'h03FF));
    exec_instr(enc_i(OPC_SW, REG_ZERO, 5'd7, 16'd5));
    issue_request(OP_READ_MEM, 32'd0, 10'd5, 32'd0);
    exec_instr(enc_i(OPC_LW, 5'd2, 5'd10, 16'd0));
    exec_instr(enc_i(OPC_SW, REG_ZERO, 5'd7, 16'h0400));
    exec_instr(enc_i(OPC_LW, REG_ZERO, 5'd11, 16'hFFFF));
    exec_instr(enc_i(OPC_BEQ, REG_ZERO, REG_ZERO, 16'hFFFF));
    exec_instr(enc_i(OPC_BEQ, 5'd1, 5'd2, 16'h7FFF));
    exec_instr({OPC_J, 26'h3FF_FFFF});
    exec_instr(32'hFC00_1234);
    issue_request(OP_READ_REG, 32'd0, 10'd10, 32'd0);
  endtask

  task automatic test_random(input int unsigned count, input bit with_idle);
    logic [31:0] w;
    logic [9:0]  idx;
    logic [4:0]  rs;
    logic [31:0] target;
    op_e         op;
    int unsigned kind;
    tx_idle_en = with_idle;
    rx_idle_en = with_idle;
    repeat (count) begin
      w = $urandom;
      idx = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
      op = OP_EXEC;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        w[31:26] = $urandom_range(0, 1) ? OPC_RTYPE2 : OPC_RTYPE;
        case ($urandom_range(0, 6))
          0: w[5:0] = FN_ADD;
          1: w[5:0] = FN_SUB;
          2: w[5:0] = FN_AND;
          3: w[5:0] = FN_OR;
          4: w[5:0] = FN_NOR;
          5: w[5:0] = FN_MUL;
          default: ;
        endcase
      end else if (kind < 42) begin
        w[31:26] = OPC_ADDI;
        if ($urandom_range(0, 1) == 0) w[25:21] = REG_ZERO;
      end else if (kind < 62) begin
        w[31:26] = $urandom_range(0, 1) ? OPC_LW : OPC_SW;
        if ($urandom_range(0, 7) != 0) begin
          target = ($urandom_range(0, 3) == 0) ? $urandom_range(0, DATA_WORDS - 1)
                                               : $urandom_range(0, 63);
          rs = w[25:21];
          if (gpr[rs] > target) rs = REG_ZERO;
          w[25:21] = rs;
          w[15:0] = 16'(target - gpr[rs]);
        end
      end else if (kind < 70) begin
        w[31:26] = OPC_BEQ;
        if ($urandom_range(0, 1) == 0) w[20:16] = w[25:21];
      end else if (kind < 74) begin
        w[31:26] = OPC_J;
      end else if (kind < 78) begin
        op = OP_EXEC;
      end else if (kind < 86) begin
        op = OP_PRELOAD;
      end else if (kind < 94) begin
        op = OP_READ_REG;
        idx = 10'($urandom);
      end else begin
        op = OP_READ_MEM;
      end
      if (w == HALT_WORD) w[0] = 1'b0;
      issue_request(op, w, idx, $urandom);
    end
  endtask

  task automatic test_backpressure();
    rx_hold_left = 300;
    test_random(40, 1'b0);
  endtask

  task automatic test_drain_pause();
    test_random(30, 1'b1);
    wait_results_drained();
    test_random(30, 1'b1);
  endtask

  task automatic test_halt();
    exec_instr(HALT_WORD);
    exec_instr(enc_i(OPC_ADDI, REG_ZERO, 5'd12, 16'h1234));
    exec_instr({OPC_J, 26'h155_5555});
    exec_instr(HALT_WORD);
    issue_request(OP_PRELOAD, 32'd0, 10'd9, 32'h1357_9BDF);
    issue_request(OP_READ_MEM, 32'd0, 10'd9, 32'd0);
    issue_request(OP_READ_REG, 32'd0, 10'd12, 32'd0);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        rx_gap_left = $urandom_range(0, 11);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_r = m_axis_tdata[65:0];
      if (pending_results.size() == 0) begin
        $error("result with no pending request: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want_r = pending_results.pop_front();
        if (got_r.next_pc !== want_r.next_pc) begin
          $error("next_pc: expected %h, got %h", want_r.next_pc, got_r.next_pc);
          mismatches++;
        end
        if (got_r.halted !== want_r.halted) begin
          $error("halted: expected %b, got %b", want_r.halted, got_r.halted);
          mismatches++;
        end
        if (got_r.read_value !== want_r.read_value) begin
          $error("read_value: expected %h, got %h", want_r.read_value, got_r.read_value);
          mismatches++;
        end
        if (got_r.fault !== want_r.fault) begin
          $error("fault: expected %b, got %b", want_r.fault, got_r.fault);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_EXEC;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    rx_hold_left = 0;
    rx_gap_left = 0;
    mismatches = 0;
    cycles = 0;
    pc_q = '0;
    halt_q = 1'b0;
    foreach (gpr[i]) gpr[i] = '0;
    foreach (dmem[i]) dmem[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_alu_ops();
    test_memory_and_branch();
    test_backpressure();
    test_drain_pause();
    test_random(700, 1'b1);
    test_random(100, 1'b0);
    test_halt();
    wait_results_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
